// File: design/stereo_convolution_reverb_defines.svh
// assertion macros shared by the stereo convolution reverb rtl
// no dependencies; assumes the asserting module has aclk and aresetn
`ifndef STEREO_CONVOLUTION_REVERB_DEFINES_SVH
`define STEREO_CONVOLUTION_REVERB_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside of reset
`define SCR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("scr: assertion failed");

// property checked on every clock edge, reset included
`define SCR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("scr: assertion failed");

`else

`define SCR_ASSERT(lbl, prop)
`define SCR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: design/scr_pkg.sv
// shared constants, types and register codes of the stereo convolution reverb
// no dependencies
package scr_pkg;

    // impulse storage and history sizing
    localparam int MAX_TAPS   = 1024;
    localparam int TAP_AW     = $clog2(MAX_TAPS);
    localparam int HIST_DEPTH = 2 * MAX_TAPS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int EFF_LEN_W  = TAP_AW + 1;

    // field widths
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int LEN_W      = 11;
    localparam int TAP_IDX_W  = 10;

    // input tdata layout, lowest field first
    localparam int OFF_LEFT   = 0;
    localparam int OFF_RIGHT  = OFF_LEFT + SAMPLE_W;
    localparam int OFF_IDX    = OFF_RIGHT + SAMPLE_W;
    localparam int OFF_TAP_L  = OFF_IDX + TAP_IDX_W;
    localparam int OFF_TAP_R  = OFF_TAP_L + SAMPLE_W;
    localparam int S_FIELDS_W = OFF_TAP_R + SAMPLE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 2 * SAMPLE_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // convolution accumulator, rounded from Q.46 to Q.23
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = PROD_W + TAP_AW;
    localparam int CONV_FRAC  = SAMPLE_W - 1;
    localparam int CONV_W     = ACC_W + 1 - CONV_FRAC;
    localparam logic [ACC_W:0] CONV_RND = (ACC_W + 1)'(1) << (CONV_FRAC - 1);

    // gain mix, rounded from Q.35 to Q.23
    localparam int MIX_FRAC   = GAIN_W - 4;
    localparam int MPROD_W    = GAIN_W + CONV_W;
    localparam int MIX_W      = MPROD_W + 2;
    localparam int MRND_W     = MIX_W + 1 - MIX_FRAC;
    localparam logic [MIX_W:0] MIX_RND = (MIX_W + 1)'(1) << (MIX_FRAC - 1);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMPULSE_LEN  = 3'd0,
        REG_DRY_GAIN     = 3'd1,
        REG_WET_DIRECT_L = 3'd2,
        REG_WET_CROSS_L  = 3'd3,
        REG_WET_DIRECT_R = 3'd4,
        REG_WET_CROSS_R  = 3'd5
    } cfg_reg_t;

    // request kinds carried on tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0] dry;
        logic signed [GAIN_W-1:0] wet_direct_l;
        logic signed [GAIN_W-1:0] wet_cross_l;
        logic signed [GAIN_W-1:0] wet_direct_r;
        logic signed [GAIN_W-1:0] wet_cross_r;
    } gains_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mix_stat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       clipped;
    } mix_res_t;

endpackage

// File: design/scr_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module scr_ram #(
    parameter int AW = 10,
    parameter int DW = 48
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: design/scr_mac.sv
// multiply-accumulate unit for the left and right convolutions, one multiplier per channel
// depends on scr_pkg
module scr_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  scr_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [scr_pkg::SAMPLE_W-1:0] tap_l,
    input  logic signed [scr_pkg::SAMPLE_W-1:0] tap_r,
    input  logic signed [scr_pkg::SAMPLE_W-1:0] hist_l,
    input  logic signed [scr_pkg::SAMPLE_W-1:0] hist_r,
    output logic                                busy,
    output logic signed [scr_pkg::CONV_W-1:0]   conv_l,
    output logic signed [scr_pkg::CONV_W-1:0]   conv_r
);
    import scr_pkg::*;

    logic signed [PROD_W-1:0] prod_l_reg, prod_r_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_l_reg, acc_r_reg;
    logic [ACC_W:0]           rnd_l, rnd_r;

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.valid;
        end
        prod_l_reg <= tap_l * hist_l;
        prod_r_reg <= tap_r * hist_r;
    end

    // accumulate stage
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_l_reg <= acc_l_reg + {{(ACC_W-PROD_W){prod_l_reg[PROD_W-1]}}, prod_l_reg};
            acc_r_reg <= acc_r_reg + {{(ACC_W-PROD_W){prod_r_reg[PROD_W-1]}}, prod_r_reg};
        end
    end

    assign busy = prod_vld_reg;

    // round half up to q.23 by taking the floor of the upper bits
    assign rnd_l  = {acc_l_reg[ACC_W-1], acc_l_reg} + CONV_RND;
    assign rnd_r  = {acc_r_reg[ACC_W-1], acc_r_reg} + CONV_RND;
    assign conv_l = $signed(rnd_l[ACC_W:CONV_FRAC]);
    assign conv_r = $signed(rnd_r[ACC_W:CONV_FRAC]);

endmodule

// File: design/scr_mix.sv
// gain mixer: six gain products through one multiplier, then round and saturate
// depends on scr_pkg
module scr_mix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  scr_pkg::gains_t                     gains,
    input  logic signed [scr_pkg::CONV_W-1:0]   conv_l,
    input  logic signed [scr_pkg::CONV_W-1:0]   conv_r,
    input  logic signed [scr_pkg::SAMPLE_W-1:0] dry_l,
    input  logic signed [scr_pkg::SAMPLE_W-1:0] dry_r,
    output scr_pkg::mix_stat_t                  stat,
    output scr_pkg::mix_res_t                   res
);
    import scr_pkg::*;

    typedef enum logic [2:0] {
        STEP_DRY_L, STEP_WD_L, STEP_WC_L,
        STEP_DRY_R, STEP_WD_R, STEP_WC_R,
        STEP_ACC, STEP_DONE
    } step_t;

    step_t                     step_reg;
    logic                      busy_reg;
    logic signed [CONV_W-1:0]  cl_reg, cr_reg, dl_reg, dr_reg;
    logic signed [MPROD_W-1:0] prod_reg;
    logic                      prod_vld_reg, prod_left_reg;
    logic signed [MIX_W-1:0]   acc_l_reg, acc_r_reg;
    logic signed [GAIN_W-1:0]  gain_sel;
    logic signed [CONV_W-1:0]  op_sel;
    logic                      mul_en, mul_left;
    logic [MIX_W:0]            rnd_l, rnd_r;
    logic [MRND_W-1:0]         rv_l, rv_r;
    logic                      ovf_l, ovf_r;

    // operand select per step
    always_comb begin
        gain_sel = gains.dry;
        op_sel   = dl_reg;
        mul_en   = busy_reg;
        mul_left = 1'b1;
        case (step_reg)
            STEP_DRY_L: begin
                gain_sel = gains.dry;
                op_sel   = dl_reg;
            end
            STEP_WD_L: begin
                gain_sel = gains.wet_direct_l;
                op_sel   = cl_reg;
            end
            STEP_WC_L: begin
                gain_sel = gains.wet_cross_l;
                op_sel   = cr_reg;
            end
            STEP_DRY_R: begin
                gain_sel = gains.dry;
                op_sel   = dr_reg;
                mul_left = 1'b0;
            end
            STEP_WD_R: begin
                gain_sel = gains.wet_direct_r;
                op_sel   = cr_reg;
                mul_left = 1'b0;
            end
            STEP_WC_R: begin
                gain_sel = gains.wet_cross_r;
                op_sel   = cl_reg;
                mul_left = 1'b0;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= STEP_DRY_L;
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= mul_en;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_DRY_L;
            end else if (busy_reg) begin
                if (step_reg == STEP_DONE) begin
                    busy_reg <= 1'b0;
                end else begin
                    step_reg <= step_t'(step_reg + 3'd1);
                end
            end
        end
    end

    // operand capture, shared multiplier and accumulators
    always_ff @(posedge aclk) begin
        if (start) begin
            cl_reg    <= conv_l;
            cr_reg    <= conv_r;
            dl_reg    <= $signed({{(CONV_W-SAMPLE_W){dry_l[SAMPLE_W-1]}}, dry_l});
            dr_reg    <= $signed({{(CONV_W-SAMPLE_W){dry_r[SAMPLE_W-1]}}, dry_r});
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (prod_vld_reg) begin
            if (prod_left_reg) begin
                acc_l_reg <= acc_l_reg + {{(MIX_W-MPROD_W){prod_reg[MPROD_W-1]}}, prod_reg};
            end else begin
                acc_r_reg <= acc_r_reg + {{(MIX_W-MPROD_W){prod_reg[MPROD_W-1]}}, prod_reg};
            end
        end
        prod_reg      <= gain_sel * op_sel;
        prod_left_reg <= mul_left;
    end

    // round half up to q.23 and saturate to 24 bits
    assign rnd_l = {acc_l_reg[MIX_W-1], acc_l_reg} + MIX_RND;
    assign rnd_r = {acc_r_reg[MIX_W-1], acc_r_reg} + MIX_RND;
    assign rv_l  = rnd_l[MIX_W:MIX_FRAC];
    assign rv_r  = rnd_r[MIX_W:MIX_FRAC];
    assign ovf_l = !((&rv_l[MRND_W-1:SAMPLE_W-1]) || !(|rv_l[MRND_W-1:SAMPLE_W-1]));
    assign ovf_r = !((&rv_r[MRND_W-1:SAMPLE_W-1]) || !(|rv_r[MRND_W-1:SAMPLE_W-1]));

    always_comb begin
        res.left  = $signed(rv_l[SAMPLE_W-1:0]);
        res.right = $signed(rv_r[SAMPLE_W-1:0]);
        if (ovf_l) begin
            res.left = $signed({rv_l[MRND_W-1], {(SAMPLE_W-1){!rv_l[MRND_W-1]}}});
        end
        if (ovf_r) begin
            res.right = $signed({rv_r[MRND_W-1], {(SAMPLE_W-1){!rv_r[MRND_W-1]}}});
        end
        res.clipped = ovf_l || ovf_r;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (step_reg == STEP_DONE);

endmodule

// File: design/stereo_convolution_reverb.sv
// Stereo convolution reverb, direct-form sum with one shared MAC per channel.
// Sample request: an accepted sample passes through the tap loop, the MAC drain, the gain
// mix and the output register before its result is valid.
// Load request: written to the tap store on accept. One request in flight; an untaken result holds back the next one.
// Reset (aresetn low, synchronous): registers to defaults, then a clearing pass over all 2048
// history entries during which no request is taken; config writes are taken always.
`include "stereo_convolution_reverb_defines.svh"

module stereo_convolution_reverb (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // left_sample, right_sample, tap_index, tap_left, tap_right, zero pad
    input  logic [scr_pkg::S_TDATA_W-1:0]    s_tdata,
    // func
    input  logic                             s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // left_out, right_out
    output logic [scr_pkg::M_TDATA_W-1:0]    m_tdata,
    // clipped
    output logic                             m_tuser,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import scr_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MAC, ST_DRAIN, ST_MIX, ST_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [HIST_AW-1:0]         clr_reg;
    logic [HIST_AW-1:0]         ptr_reg;
    logic [HIST_AW-1:0]         haddr_reg;
    logic [TAP_AW-1:0]          k_reg;
    logic [EFF_LEN_W-1:0]       len_reg;
    logic                       rdv_reg, first_reg;
    logic signed [SAMPLE_W-1:0] dl_reg, dr_reg;
    logic [LEN_W-1:0]           len_cfg_reg;
    gains_t                     gains_reg;
    logic                       m_tvalid_reg, m_tuser_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;

    logic                       s_req, sample_req, load_req, last_tap, out_free, mix_start;
    logic [EFF_LEN_W-1:0]       eff_len;
    logic [TAP_IDX_W-1:0]       in_idx;
    logic                       hist_we;
    logic [HIST_AW-1:0]         hist_waddr;
    logic [2*SAMPLE_W-1:0]      hist_wdata, hist_q, tap_q;
    mac_ctrl_t                  mac_ctrl;
    logic                       mac_busy;
    logic signed [CONV_W-1:0]   conv_l, conv_r;
    mix_stat_t                  mix_stat;
    mix_res_t                   mix_res;

    // request decode
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_req      = s_tvalid && s_tready;
    assign sample_req = s_req && (s_tuser == FUNC_SAMPLE);
    assign load_req   = s_req && (s_tuser == FUNC_LOAD) && (32'(in_idx) < MAX_TAPS);
    assign in_idx     = s_tdata[OFF_IDX +: TAP_IDX_W];
    assign cfg_ready  = 1'b1;

    // taps in use, zero acts as one and the top is capped at the tap store size
    always_comb begin
        if (len_cfg_reg == '0) begin
            eff_len = EFF_LEN_W'(1);
        end else if (32'(len_cfg_reg) > MAX_TAPS) begin
            eff_len = EFF_LEN_W'(MAX_TAPS);
        end else begin
            eff_len = EFF_LEN_W'(len_cfg_reg);
        end
    end

    // tap store, left tap in the low half
    scr_ram #(.AW(TAP_AW), .DW(2*SAMPLE_W)) u_tap_ram (
        .aclk  (aclk),
        .we    (load_req),
        .waddr (TAP_AW'(in_idx)),
        .wdata ({s_tdata[OFF_TAP_R +: SAMPLE_W], s_tdata[OFF_TAP_L +: SAMPLE_W]}),
        .raddr (k_reg),
        .rdata (tap_q)
    );

    // history store, written by the clearing pass or by a sample request
    assign hist_we    = (state_reg == ST_CLEAR) || sample_req;
    assign hist_waddr = (state_reg == ST_CLEAR) ? clr_reg : ptr_reg;
    assign hist_wdata = (state_reg == ST_CLEAR) ? '0 :
                        {s_tdata[OFF_RIGHT +: SAMPLE_W], s_tdata[OFF_LEFT +: SAMPLE_W]};

    scr_ram #(.AW(HIST_AW), .DW(2*SAMPLE_W)) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (haddr_reg),
        .rdata (hist_q)
    );

    // shared multiply-accumulate
    assign mac_ctrl.clear = sample_req;
    assign mac_ctrl.valid = rdv_reg;

    scr_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .tap_l   ($signed(tap_q[SAMPLE_W-1:0])),
        .tap_r   ($signed(tap_q[2*SAMPLE_W-1:SAMPLE_W])),
        .hist_l  ($signed(hist_q[SAMPLE_W-1:0])),
        .hist_r  ($signed(hist_q[2*SAMPLE_W-1:SAMPLE_W])),
        .busy    (mac_busy),
        .conv_l  (conv_l),
        .conv_r  (conv_r)
    );

    // gain mixer
    assign mix_start = (state_reg == ST_DRAIN) && !rdv_reg && !mac_busy;

    scr_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .gains   (gains_reg),
        .conv_l  (conv_l),
        .conv_r  (conv_r),
        .dry_l   (dl_reg),
        .dry_r   (dr_reg),
        .stat    (mix_stat),
        .res     (mix_res)
    );

    // sequencer next state
    assign last_tap = ({1'b0, k_reg} == (len_reg - EFF_LEN_W'(1)));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (sample_req) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mix_start) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                if (mix_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, counters, config registers and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            ptr_reg      <= '0;
            rdv_reg      <= 1'b0;
            first_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            len_cfg_reg  <= LEN_W'(1024);
            gains_reg    <= '{dry: 16'sd4096, wet_direct_l: 16'sd4096, wet_cross_l: 16'sd0,
                              wet_direct_r: 16'sd4096, wet_cross_r: 16'sd0};
        end else begin
            state_reg <= state_next;
            rdv_reg   <= (state_reg == ST_MAC);
            first_reg <= (state_reg == ST_MAC) && (k_reg == '0);

            // clearing pass
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + HIST_AW'(1);
            end

            // sample request starts the tap loop at the entry eff_len samples back, then steps to older ones
            if (sample_req) begin
                ptr_reg   <= ptr_reg + HIST_AW'(1);
                haddr_reg <= ptr_reg - HIST_AW'(eff_len);
                len_reg   <= eff_len;
                k_reg     <= '0;
            end else if (state_reg == ST_MAC) begin
                haddr_reg <= haddr_reg - HIST_AW'(1);
                k_reg     <= k_reg + TAP_AW'(1);
            end

            // result register
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {mix_res.right, mix_res.left};
                m_tuser_reg  <= mix_res.clipped;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMPULSE_LEN:  len_cfg_reg            <= cfg_data[LEN_W-1:0];
                    REG_DRY_GAIN:     gains_reg.dry          <= $signed(cfg_data);
                    REG_WET_DIRECT_L: gains_reg.wet_direct_l <= $signed(cfg_data);
                    REG_WET_CROSS_L:  gains_reg.wet_cross_l  <= $signed(cfg_data);
                    REG_WET_DIRECT_R: gains_reg.wet_direct_r <= $signed(cfg_data);
                    REG_WET_CROSS_R:  gains_reg.wet_cross_r  <= $signed(cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    // delayed dry sample is the first history word of the tap loop
    always_ff @(posedge aclk) begin
        if (first_reg) begin
            dl_reg <= $signed(hist_q[SAMPLE_W-1:0]);
            dr_reg <= $signed(hist_q[2*SAMPLE_W-1:SAMPLE_W]);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `SCR_ASSERT(a_idle_empty, (state_reg == ST_IDLE) |-> (!rdv_reg && !mac_busy && !mix_stat.busy))
    `SCR_ASSERT(a_clear_no_read, (state_reg == ST_CLEAR) |-> (!rdv_reg && !mac_busy))
    `SCR_ASSERT(a_tap_in_range, (state_reg == ST_MAC) |-> ({1'b0, k_reg} < len_reg))
    `SCR_ASSERT(a_ptr_step, sample_req |=> (ptr_reg == $past(ptr_reg) + HIST_AW'(1)))

endmodule

// File: verif/stereo_convolution_reverb_tb.sv
// testbench for stereo_convolution_reverb: a scoreboard class with a bit-exact direct-form
// predictor, stream and register drivers, and a result checker on the master side
// depends on scr_pkg and the stereo_convolution_reverb rtl

class reverb_scoreboard;
    // impulse taps, input history and copies of the registers
    logic signed [scr_pkg::SAMPLE_W-1:0] tap_l  [scr_pkg::MAX_TAPS];
    logic signed [scr_pkg::SAMPLE_W-1:0] tap_r  [scr_pkg::MAX_TAPS];
    logic signed [scr_pkg::SAMPLE_W-1:0] hist_l [scr_pkg::HIST_DEPTH];
    logic signed [scr_pkg::SAMPLE_W-1:0] hist_r [scr_pkg::HIST_DEPTH];
    int unsigned                         wr_ptr;
    logic [scr_pkg::LEN_W-1:0]           impulse_len;
    logic signed [scr_pkg::GAIN_W-1:0]   gain_dry;
    logic signed [scr_pkg::GAIN_W-1:0]   gain_direct_l;
    logic signed [scr_pkg::GAIN_W-1:0]   gain_cross_l;
    logic signed [scr_pkg::GAIN_W-1:0]   gain_direct_r;
    logic signed [scr_pkg::GAIN_W-1:0]   gain_cross_r;

    // stereo results still owed by the block, oldest first
    scr_pkg::mix_res_t expected_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       clipped_seen;
    int unsigned       samples;
    int unsigned       loads;

    function new();
        foreach (tap_l[i]) begin
            tap_l[i] = '0;
            tap_r[i] = '0;
        end
        foreach (hist_l[i]) begin
            hist_l[i] = '0;
            hist_r[i] = '0;
        end
        wr_ptr        = 0;
        impulse_len   = 11'd1024;
        gain_dry      = 16'sd4096;
        gain_direct_l = 16'sd4096;
        gain_cross_l  = 16'sd0;
        gain_direct_r = 16'sd4096;
        gain_cross_r  = 16'sd0;
        errors        = 0;
        checked       = 0;
        clipped_seen  = 0;
        samples       = 0;
        loads         = 0;
    endfunction

    function void set_reg(input logic [scr_pkg::CFG_IDX_W-1:0] idx,
                          input logic [scr_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            scr_pkg::REG_IMPULSE_LEN:  impulse_len   = value[scr_pkg::LEN_W-1:0];
            scr_pkg::REG_DRY_GAIN:     gain_dry      = value;
            scr_pkg::REG_WET_DIRECT_L: gain_direct_l = value;
            scr_pkg::REG_WET_CROSS_L:  gain_cross_l  = value;
            scr_pkg::REG_WET_DIRECT_R: gain_direct_r = value;
            scr_pkg::REG_WET_CROSS_R:  gain_cross_r  = value;
            default: ;
        endcase
    endfunction

    // round to nearest by adding half an lsb and flooring
    function longint round_q(input longint v, input int unsigned s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function logic signed [scr_pkg::SAMPLE_W-1:0] clamp24(input longint v, inout bit clip);
        if (v > 64'sd8388607) begin
            clip = 1'b1;
            v    = 64'sd8388607;
        end else if (v < -64'sd8388608) begin
            clip = 1'b1;
            v    = -64'sd8388608;
        end
        return v[scr_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_request(input logic func, input logic [scr_pkg::S_TDATA_W-1:0] data);
        int unsigned       len;
        int unsigned       idx;
        int unsigned       h;
        int unsigned       k;
        longint            acc_l;
        longint            acc_r;
        longint            conv_l;
        longint            conv_r;
        longint            mix_l;
        longint            mix_r;
        bit                clip;
        scr_pkg::mix_res_t res;

        // tap load: no result, history untouched
        if (func == scr_pkg::FUNC_LOAD) begin
            idx = 32'(data[scr_pkg::OFF_IDX +: scr_pkg::TAP_IDX_W]);
            if (idx < scr_pkg::MAX_TAPS) begin
                tap_l[idx] = data[scr_pkg::OFF_TAP_L +: scr_pkg::SAMPLE_W];
                tap_r[idx] = data[scr_pkg::OFF_TAP_R +: scr_pkg::SAMPLE_W];
            end
            loads++;
            return;
        end

        // length register clamps to 1..MAX_TAPS
        len = 32'(impulse_len);
        if (len < 1)
            len = 1;
        if (len > scr_pkg::MAX_TAPS)
            len = scr_pkg::MAX_TAPS;

        hist_l[wr_ptr] = data[scr_pkg::OFF_LEFT +: scr_pkg::SAMPLE_W];
        hist_r[wr_ptr] = data[scr_pkg::OFF_RIGHT +: scr_pkg::SAMPLE_W];

        // exact convolution of the input delayed by len
        acc_l = 0;
        acc_r = 0;
        for (k = 0; k < len; k++) begin
            h = (wr_ptr + scr_pkg::HIST_DEPTH - len - k) % scr_pkg::HIST_DEPTH;
            acc_l += longint'(tap_l[k]) * longint'(hist_l[h]);
            acc_r += longint'(tap_r[k]) * longint'(hist_r[h]);
        end
        conv_l = round_q(acc_l, 23);
        conv_r = round_q(acc_r, 23);

        // dry path plus direct and cross wet paths
        h     = (wr_ptr + scr_pkg::HIST_DEPTH - len) % scr_pkg::HIST_DEPTH;
        mix_l = longint'(gain_dry) * longint'(hist_l[h]) + longint'(gain_direct_l) * conv_l
              + longint'(gain_cross_l) * conv_r;
        mix_r = longint'(gain_dry) * longint'(hist_r[h]) + longint'(gain_direct_r) * conv_r
              + longint'(gain_cross_r) * conv_l;

        clip        = 1'b0;
        res.left    = clamp24(round_q(mix_l, 12), clip);
        res.right   = clamp24(round_q(mix_r, 12), clip);
        res.clipped = clip;
        expected_q.push_back(res);
        wr_ptr = (wr_ptr + 1) % scr_pkg::HIST_DEPTH;
        samples++;
    endfunction

    function void check_result(input logic [scr_pkg::M_TDATA_W-1:0] data, input logic clip_flag);
        scr_pkg::mix_res_t                   want;
        logic signed [scr_pkg::SAMPLE_W-1:0] got_l;
        logic signed [scr_pkg::SAMPLE_W-1:0] got_r;

        got_l = data[0 +: scr_pkg::SAMPLE_W];
        got_r = data[scr_pkg::SAMPLE_W +: scr_pkg::SAMPLE_W];
        if (expected_q.size() == 0) begin
            $error("result with no sample request waiting: left_out %0d right_out %0d",
                   got_l, got_r);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (want.clipped)
            clipped_seen++;
        if (got_l !== want.left) begin
            $error("left_out mismatch: expected %0d, got %0d", want.left, got_l);
            errors++;
        end
        if (got_r !== want.right) begin
            $error("right_out mismatch: expected %0d, got %0d", want.right, got_r);
            errors++;
        end
        if (clip_flag !== want.clipped) begin
            $error("clipped mismatch: expected %0b, got %0b", want.clipped, clip_flag);
            errors++;
        end
    endfunction
endclass

module stereo_convolution_reverb_tb;
    import scr_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 15;
    localparam int ITEMS_PER_PHASE = 29;
    // taps given a value up front, above every length that the run selects
    localparam int PRELOAD_TAPS    = 128;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = 16'sh7FFF;
    localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = 16'sh8000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = FUNC_SAMPLE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMPULSE_LEN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned eff_len       = MAX_TAPS;
    int unsigned settings_used = 0;

    // length words per random phase, zero and junk upper bits included, all within the
    // preloaded taps
    logic [CFG_DATA_W-1:0] phase_len [RANDOM_PHASES] =
        '{16'd1, 16'd0, 16'hF802, 16'd3, 16'd5, 16'd8, 16'd100, 16'd16, 16'd33, 16'd64,
          16'hF87F, 16'd4, 16'd11, 16'd127, 16'd6};

    reverb_scoreboard sb = new();

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    stereo_convolution_reverb dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // result side: check each accepted result, then choose the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // hang guard
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] pack_request(
        input logic signed [SAMPLE_W-1:0] left,
        input logic signed [SAMPLE_W-1:0] right,
        input logic [TAP_IDX_W-1:0]       idx,
        input logic signed [SAMPLE_W-1:0] tl,
        input logic signed [SAMPLE_W-1:0] tr);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OFF_LEFT  +: SAMPLE_W]  = left;
        d[OFF_RIGHT +: SAMPLE_W]  = right;
        d[OFF_IDX   +: TAP_IDX_W] = idx;
        d[OFF_TAP_L +: SAMPLE_W]  = tl;
        d[OFF_TAP_R +: SAMPLE_W]  = tr;
        return d;
    endfunction

    // full-scale corners now and then, otherwise random at a random scale
    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int unsigned max_shift);
        logic signed [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom);
        case ($urandom_range(0, 11))
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            2:       v = '0;
            default: v = v >>> $urandom_range(0, max_shift);
        endcase
        return v;
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        logic signed [GAIN_W-1:0] v;
        v = GAIN_W'($urandom);
        case ($urandom_range(0, 9))
            0:       v = GAIN_MAX;
            1:       v = GAIN_MIN;
            2:       v = '0;
            default: v = v >>> $urandom_range(0, 4);
        endcase
        return v;
    endfunction

    // one request on the slave side, with random idle cycles ahead of it
    task automatic send_request(input logic func, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, data);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] left,
                               input logic signed [SAMPLE_W-1:0] right);
        send_request(FUNC_SAMPLE, pack_request(left, right, TAP_IDX_W'($urandom),
                                               SAMPLE_W'($urandom), SAMPLE_W'($urandom)));
    endtask

    task automatic send_random_item();
        logic [S_TDATA_W-1:0] d;
        d = pack_request(rand_sample(8), rand_sample(8),
                         TAP_IDX_W'($urandom_range(0, MAX_TAPS - 1)),
                         rand_sample(10), rand_sample(10));
        if ($urandom_range(0, 99) < 15)
            send_request(FUNC_LOAD, d);
        else
            send_request(FUNC_SAMPLE, d);
    endtask

    // hold off the sender until every owed result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // drained, plus one pass of the tap loop for a trailing load
    task automatic settle();
        wait_results_drained();
        repeat (eff_len + 20) @(posedge aclk);
    endtask

    // register write; valid stays high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] len_word,
                                  input logic signed [GAIN_W-1:0] dry,
                                  input logic signed [GAIN_W-1:0] direct_l,
                                  input logic signed [GAIN_W-1:0] cross_l,
                                  input logic signed [GAIN_W-1:0] direct_r,
                                  input logic signed [GAIN_W-1:0] cross_r);
        write_reg(REG_IMPULSE_LEN, len_word);
        write_reg(REG_DRY_GAIN, dry);
        write_reg(REG_WET_DIRECT_L, direct_l);
        write_reg(REG_WET_CROSS_L, cross_l);
        write_reg(REG_WET_DIRECT_R, direct_r);
        write_reg(REG_WET_CROSS_R, cross_r);
        cfg_valid <= 1'b0;
        eff_len = 32'(len_word[LEN_W-1:0]);
        if (eff_len == 0)
            eff_len = 1;
        else if (eff_len > MAX_TAPS)
            eff_len = MAX_TAPS;
        settings_used++;
    endtask

    initial begin
        int unsigned i;
        int unsigned p;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // config is taken during the clearing pass; spare indexes first
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h5A5A);
        apply_settings(16'd4, 16'sd4096, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0);

        // every tap that a selected length reaches gets a value before any sample reads it
        send_idle_pct = 32;
        recv_idle_pct = 52;
        for (i = 0; i < PRELOAD_TAPS; i++)
            send_request(FUNC_LOAD, pack_request(rand_sample(8), rand_sample(8),
                                                 TAP_IDX_W'(i), rand_sample(10),
                                                 rand_sample(10)));

        // directed: corner taps, then full-scale samples into an empty history
        send_request(FUNC_LOAD, pack_request('0, '0, '0, SAMPLE_MAX, SAMPLE_MAX));
        send_request(FUNC_LOAD, pack_request('0, '0, 10'd1, SAMPLE_MIN, SAMPLE_MAX));
        send_request(FUNC_LOAD, pack_request(SAMPLE_MAX, SAMPLE_MIN, TAP_IDX_W'(MAX_TAPS - 1),
                                             SAMPLE_MIN, SAMPLE_MIN));
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample('0, '0);
        send_sample(-24'sd1, 24'sd1);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        send_sample(24'sd1, -24'sd1);
        repeat (5) send_sample(rand_sample(8), rand_sample(8));
        wait_results_drained();
        send_sample(SAMPLE_MAX, '0);
        send_sample('0, SAMPLE_MIN);
        settle();

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (p = 0; p < RANDOM_PHASES; p++) begin
            send_idle_pct = (p < 5) ? 32 : (p < 10) ? 52 : 0;
            recv_idle_pct = (p < 5) ? 52 : (p < 10) ? 32 : 0;
            if (p == 3)
                apply_settings(phase_len[p], GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
            else if (p == 9)
                apply_settings(phase_len[p], GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
            else
                apply_settings(phase_len[p], rand_gain(), rand_gain(), rand_gain(),
                               rand_gain(), rand_gain());
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 39) == 0)
                    wait_results_drained();
                send_random_item();
            end
            settle();
        end

        $display("covered %0d sample and %0d tap load requests over %0d register settings",
                 sb.samples, sb.loads, settings_used);
        $display("checked %0d stereo results, %0d of them clipped", sb.checked, sb.clipped_seen);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
